// ----- design/assert_macros.svh -----
// Assertion macros shared by the point-in-polygon RTL.
// Included by modules that check their own logic; depends on nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define PIP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// A condition in one cycle requires an expression in the next.
`define PIP_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

// ----- design/pip_pkg.sv -----
// Package for the point-in-polygon crossing test: widths, types and helpers.
// Used by every module of the block and by pip_req_if; depends on nothing.
`default_nettype none

package pip_pkg;

   // Field widths.
   localparam int VERTEX_BITS = 16;
   localparam int QUERY_BITS  = 20;
   localparam int FRAC_BITS   = 4;
   localparam int FRAC_SCALE  = 1 << FRAC_BITS;
   localparam int FAR_COORD   = 9999;

   // Vertices are scaled to the query's fixed point.
   localparam int SCALED_BITS = VERTEX_BITS + FRAC_BITS;
   localparam int WIDE_BITS   = (SCALED_BITS > QUERY_BITS) ? SCALED_BITS : QUERY_BITS;
   // One extra bit holds any difference of two scaled coordinates.
   localparam int DIFF_BITS   = WIDE_BITS + 1;
   localparam int PROD_BITS   = 2 * DIFF_BITS;
   localparam int SUM_BITS    = PROD_BITS + 1;

   typedef logic signed [VERTEX_BITS-1:0] vertex_type;
   typedef logic signed [QUERY_BITS-1:0]  query_type;
   typedef logic signed [DIFF_BITS-1:0]   diff_type;
   typedef logic signed [PROD_BITS-1:0]   prod_type;
   typedef logic signed [SUM_BITS-1:0]    sum_type;

   // Far end of the test segment, in fixed point.
   localparam diff_type FAR_FIX = DIFF_BITS'(FAR_COORD * FRAC_SCALE);

   // Operands for one edge against the query segment.
   typedef struct packed {
      diff_type va_x;   // edge direction
      diff_type va_y;
      diff_type vb_x;   // query segment direction
      diff_type vb_y;
      diff_type d_x;    // edge start minus query point
      diff_type d_y;
   } edge_ops_type;

   // Control that travels with a word down the pipeline.
   typedef struct packed {
      logic valid;
      logic started;    // an open edge exists (not the first vertex)
      logic last;       // closing edge is tested and a result is due
   } stage_ctrl_type;

   // True when n/d lies in 0..1 inclusive; a zero denominator never counts.
   function automatic logic in_unit(input sum_type n, input sum_type d);
      logic ok;
      if (d == '0) begin
         ok = 1'b0;
      end else if (!d[SUM_BITS-1]) begin
         ok = !n[SUM_BITS-1] && (n <= d);
      end else begin
         ok = ((n == '0) || n[SUM_BITS-1]) && (n >= d);
      end
      return ok;
   endfunction

   // Scale an integer vertex coordinate to fixed point at difference width.
   function automatic diff_type scale_vertex(input vertex_type v);
      logic signed [SCALED_BITS-1:0] s;
      s = signed'({v, {FRAC_BITS{1'b0}}});
      return DIFF_BITS'(s);
   endfunction

endpackage

`default_nettype wire

// ----- design/pip_if.sv -----
// Handshake channels of the point-in-polygon block: vertex requests and results.
// Depends on pip_pkg.
`default_nettype none

interface pip_req_if import pip_pkg::*; ();
   logic       valid;
   logic       ready;
   vertex_type vertex_x;
   vertex_type vertex_y;
   query_type  query_x;
   query_type  query_y;
   logic       last_vertex;

   modport source (output valid, vertex_x, vertex_y, query_x, query_y, last_vertex,
                   input ready);
   modport sink   (input valid, vertex_x, vertex_y, query_x, query_y, last_vertex,
                   output ready);
endinterface

interface pip_rsp_if;
   logic valid;
   logic ready;
   logic inside_res;

   modport source (output valid, inside_res, input ready);
   modport sink   (input valid, inside_res, output ready);
endinterface

`default_nettype wire

// ----- design/pip_front.sv -----
// Input stage: polygon state (first, previous vertex, query) and edge operands.
// Depends on pip_pkg and pip_req_if.
`default_nettype none

module pip_front import pip_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   pip_req_if.sink        req,
   input  wire logic      advance,
   output stage_ctrl_type s1_ctrl,
   output edge_ops_type   s1_open,
   output edge_ops_type   s1_close
);

   vertex_type     first_x_ff, first_y_ff;
   vertex_type     prev_x_ff, prev_y_ff;
   query_type      held_qx_ff, held_qy_ff;
   logic           started_ff;
   stage_ctrl_type ctrl_ff, ctrl_in;
   edge_ops_type   open_ff, open_in;
   edge_ops_type   close_ff, close_in;

   diff_type cur_x, cur_y, prev_x, prev_y, first_x, first_y;
   diff_type q_x, q_y, vb_x, vb_y;
   logic     accept;

   assign req.ready = advance;
   assign accept    = req.valid && advance;

   // The query and first vertex come from the word itself when a polygon opens.
   always_comb begin
      cur_x   = scale_vertex(req.vertex_x);
      cur_y   = scale_vertex(req.vertex_y);
      prev_x  = scale_vertex(prev_x_ff);
      prev_y  = scale_vertex(prev_y_ff);
      first_x = started_ff ? scale_vertex(first_x_ff) : cur_x;
      first_y = started_ff ? scale_vertex(first_y_ff) : cur_y;
      q_x     = DIFF_BITS'(started_ff ? held_qx_ff : req.query_x);
      q_y     = DIFF_BITS'(started_ff ? held_qy_ff : req.query_y);
      vb_x    = FAR_FIX - q_x;
      vb_y    = FAR_FIX - q_y;

      // Edge from the previous vertex to this one.
      open_in.va_x = cur_x - prev_x;
      open_in.va_y = cur_y - prev_y;
      open_in.vb_x = vb_x;
      open_in.vb_y = vb_y;
      open_in.d_x  = prev_x - q_x;
      open_in.d_y  = prev_y - q_y;

      // Closing edge from this vertex back to the first.
      close_in.va_x = first_x - cur_x;
      close_in.va_y = first_y - cur_y;
      close_in.vb_x = vb_x;
      close_in.vb_y = vb_y;
      close_in.d_x  = cur_x - q_x;
      close_in.d_y  = cur_y - q_y;

      ctrl_in.valid   = req.valid;
      ctrl_in.started = started_ff;
      ctrl_in.last    = req.last_vertex;
   end

   // Polygon state is updated on every accepted word.
   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         first_x_ff <= '0;
         first_y_ff <= '0;
         prev_x_ff  <= '0;
         prev_y_ff  <= '0;
         held_qx_ff <= '0;
         held_qy_ff <= '0;
      end else if (accept) begin
         if (!started_ff) begin
            first_x_ff <= req.vertex_x;
            first_y_ff <= req.vertex_y;
            held_qx_ff <= req.query_x;
            held_qy_ff <= req.query_y;
         end
         prev_x_ff  <= req.vertex_x;
         prev_y_ff  <= req.vertex_y;
         started_ff <= !req.last_vertex;
      end
   end

   // Operand register.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (advance) begin
         ctrl_ff <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         open_ff  <= open_in;
         close_ff <= close_in;
      end
   end

   assign s1_ctrl  = ctrl_ff;
   assign s1_open  = open_ff;
   assign s1_close = close_ff;

endmodule

`default_nettype wire

// ----- design/pip_edge.sv -----
// One edge-versus-segment test: registered cross products, then exact range checks.
// Depends on pip_pkg.
`default_nettype none

module pip_edge import pip_pkg::*; (
   input  wire logic          clock,
   input  wire logic          advance,
   input  wire edge_ops_type  ops,
   output logic               crosses
);

   prod_type den_a_ff, den_b_ff, ns_a_ff, ns_b_ff, nt_a_ff, nt_b_ff;
   sum_type  den, ns, nt;

   // Six products, registered before they are combined.
   always_ff @(posedge clock) begin
      if (advance) begin
         den_a_ff <= PROD_BITS'(ops.va_x) * PROD_BITS'(ops.vb_y);
         den_b_ff <= PROD_BITS'(ops.vb_x) * PROD_BITS'(ops.va_y);
         ns_a_ff  <= PROD_BITS'(ops.va_x) * PROD_BITS'(ops.d_y);
         ns_b_ff  <= PROD_BITS'(ops.va_y) * PROD_BITS'(ops.d_x);
         nt_a_ff  <= PROD_BITS'(ops.vb_x) * PROD_BITS'(ops.d_y);
         nt_b_ff  <= PROD_BITS'(ops.vb_y) * PROD_BITS'(ops.d_x);
      end
   end

   // Both segment parameters must lie in 0..1; parallel edges give a zero denominator.
   always_comb begin
      den     = SUM_BITS'(den_a_ff) - SUM_BITS'(den_b_ff);
      ns      = SUM_BITS'(ns_a_ff) - SUM_BITS'(ns_b_ff);
      nt      = SUM_BITS'(nt_a_ff) - SUM_BITS'(nt_b_ff);
      crosses = in_unit(ns, den) && in_unit(nt, den);
   end

endmodule

`default_nettype wire

// ----- design/point_in_polygon_test_top.sv -----
// Top level of the point-in-polygon crossing test: pipeline control, parity, result.
// Depends on pip_pkg, pip_if, pip_front, pip_edge and assert_macros.svh.
//
//   channel    | direction | word
//   -----------+-----------+---------------------------------------------
//   req_chan   | in        | vertex x/y, query x/y, last_vertex
//   rsp_chan   | out       | inside_res, one word per polygon
//
// One vertex is taken per cycle while the pipeline advances.
// Stages: operand register, product register (six multipliers per edge), result register.
// A synchronous reset clears the polygon state, the crossing parity and all valid bits.
// The pipeline only stalls when a finished result waits in the output register
// and the next polygon's last vertex reaches the parity stage.
`default_nettype none
`include "assert_macros.svh"

module point_in_polygon_test_top import pip_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   pip_req_if.sink   req_chan,
   pip_rsp_if.source rsp_chan
);

   stage_ctrl_type s1_ctrl, s2_ctrl_ff;
   edge_ops_type   s1_open, s1_close;
   logic           cross_open, cross_close;
   logic           advance;
   logic           parity_ff, parity_in;
   logic           rsp_valid_ff;
   logic           inside_ff;

   // Move everything forward unless a result is due and the output is still full.
   assign advance = !(s2_ctrl_ff.valid && s2_ctrl_ff.last) || !rsp_valid_ff || rsp_chan.ready;

   pip_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_chan),
      .advance  (advance),
      .s1_ctrl  (s1_ctrl),
      .s1_open  (s1_open),
      .s1_close (s1_close)
   );

   pip_edge u_edge_open (
      .clock   (clock),
      .advance (advance),
      .ops     (s1_open),
      .crosses (cross_open)
   );

   pip_edge u_edge_close (
      .clock   (clock),
      .advance (advance),
      .ops     (s1_close),
      .crosses (cross_close)
   );

   // Control for the product stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctrl_ff <= '0;
      end else if (advance) begin
         s2_ctrl_ff <= s1_ctrl;
      end
   end

   // Parity restarts at the first vertex of each polygon.
   always_comb begin
      parity_in = (s2_ctrl_ff.started && parity_ff)
                ^ (s2_ctrl_ff.started && cross_open)
                ^ (s2_ctrl_ff.last && cross_close);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         parity_ff <= 1'b0;
      end else if (advance && s2_ctrl_ff.valid) begin
         parity_ff <= parity_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && s2_ctrl_ff.valid && s2_ctrl_ff.last) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s2_ctrl_ff.valid && s2_ctrl_ff.last) begin
         inside_ff <= parity_in;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.inside_res = inside_ff;

   // A new result only ever comes from a last vertex leaving the product stage.
   `PIP_ASSERT(a_rsp_from_last, clock, reset, rsp_valid_ff && !$past(rsp_valid_ff) |-> $past(s2_ctrl_ff.valid && s2_ctrl_ff.last), "result raised without a last vertex")

   // A last vertex that leaves the product stage always lands in the result register.
   `PIP_ASSERT_NEXT(a_last_lands, clock, reset, advance && s2_ctrl_ff.valid && s2_ctrl_ff.last, rsp_valid_ff, "last vertex produced no result")

   // The first vertex of a polygon that is not also its last leaves the parity even.
   `PIP_ASSERT_NEXT(a_parity_restart, clock, reset, advance && s2_ctrl_ff.valid && !s2_ctrl_ff.started && !s2_ctrl_ff.last, !parity_ff, "parity not cleared at polygon start")

endmodule

`default_nettype wire

// ----- tb/pip_crossing_checker.sv -----
// Scoreboard for the point-in-polygon block: watches both channels and predicts inside_res.
// Depends on pip_pkg and on the channel interfaces in pip_if.
module pip_crossing_checker import pip_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   pip_req_if        req_mon,
   pip_rsp_if        rsp_mon,
   input  wire logic run_done,
   output int        fail_count,
   output int        results_seen,
   output int        inside_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   // Products of two coordinate differences fit well within 64 bits; 128 bits leave ample headroom.
   typedef logic signed [127:0] cross_t;

   localparam longint FAR_FIXED = longint'(FAR_COORD) * FRAC_SCALE;

   // Polygon state, all coordinates held in 1/16 units.
   longint first_x, first_y;
   longint prev_x, prev_y;
   longint held_qx, held_qy;
   logic   parity;
   logic   polygon_open;

   logic   inside_expected[$];
   int     mismatches;
   int     seen_count;
   int     inside_count;
   logic   leftover_checked;

   // A ratio n/d lies in 0..1 inclusive; a zero denominator never counts.
   function automatic logic ratio_in_unit(input cross_t n, input cross_t d);
      if (d == 0) begin
         return 1'b0;
      end
      if (d > 0) begin
         return (n >= 0) && (n <= d);
      end
      return (n <= 0) && (n >= d);
   endfunction

   // Edge a->b against the segment from the held query point to the far corner.
   function automatic logic edge_crosses(input longint ax, input longint ay,
                                         input longint bx, input longint by);
      longint edge_dx, edge_dy, ray_dx, ray_dy, off_x, off_y;
      cross_t den, num_s, num_t;
      edge_dx = bx - ax;
      edge_dy = by - ay;
      ray_dx  = FAR_FIXED - held_qx;
      ray_dy  = FAR_FIXED - held_qy;
      off_x   = ax - held_qx;
      off_y   = ay - held_qy;
      den   = cross_t'(edge_dx) * cross_t'(ray_dy) - cross_t'(ray_dx) * cross_t'(edge_dy);
      num_s = cross_t'(edge_dx) * cross_t'(off_y) - cross_t'(edge_dy) * cross_t'(off_x);
      num_t = cross_t'(ray_dx) * cross_t'(off_y) - cross_t'(ray_dy) * cross_t'(off_x);
      return ratio_in_unit(num_s, den) && ratio_in_unit(num_t, den);
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
   endtask

   // Advance the polygon state by one vertex word; a last vertex queues a result.
   task automatic predict_vertex(input vertex_type vx_in, input vertex_type vy_in,
                                 input query_type qx_in, input query_type qy_in,
                                 input logic last);
      longint vx, vy;
      vx = longint'(vx_in) * FRAC_SCALE;
      vy = longint'(vy_in) * FRAC_SCALE;
      if (!polygon_open) begin
         // The first vertex latches the query point; later query fields are ignored.
         first_x      = vx;
         first_y      = vy;
         held_qx      = longint'(qx_in);
         held_qy      = longint'(qy_in);
         parity       = 1'b0;
         polygon_open = 1'b1;
      end else if (edge_crosses(prev_x, prev_y, vx, vy)) begin
         parity ^= 1'b1;
      end
      prev_x = vx;
      prev_y = vy;
      if (last) begin
         // Closing edge back to the first vertex.
         if (edge_crosses(vx, vy, first_x, first_y)) begin
            parity ^= 1'b1;
         end
         inside_expected.push_back(parity);
         polygon_open = 1'b0;
      end
   endtask

   // Both channels are sampled at the edge, before the drivers update them.
   always @(posedge clock) begin
      logic want;
      if (reset) begin
         first_x      = 0;
         first_y      = 0;
         prev_x       = 0;
         prev_y       = 0;
         held_qx      = 0;
         held_qy      = 0;
         parity       = 1'b0;
         polygon_open = 1'b0;
         leftover_checked = 1'b0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen_count++;
            if (rsp_mon.inside_res === 1'b1) begin
               inside_count++;
            end
            if (inside_expected.size() == 0) begin
               report_mismatch("result word with no polygon outstanding");
            end else begin
               want = inside_expected.pop_front();
               if (rsp_mon.inside_res !== want) begin
                  report_mismatch($sformatf("inside_res %b, expected %b",
                                            rsp_mon.inside_res, want));
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            predict_vertex(req_mon.vertex_x, req_mon.vertex_y, req_mon.query_x,
                           req_mon.query_y, req_mon.last_vertex);
         end
         if (run_done && !leftover_checked) begin
            leftover_checked = 1'b1;
            if (inside_expected.size() != 0) begin
               report_mismatch($sformatf("%0d results never arrived",
                                         inside_expected.size()));
            end
         end
      end
      fail_count   <= mismatches;
      results_seen <= seen_count;
      inside_seen  <= inside_count;
   end

endmodule

// ----- tb/tb_point_in_polygon_test_top.sv -----
// Testbench top for point_in_polygon_test_top: clock, reset, vertex stimulus and verdict.
// Depends on pip_pkg, pip_if, the block itself and pip_crossing_checker.
module tb_point_in_polygon_test_top import pip_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock;
   logic reset;
   logic run_done;
   int   fail_count;
   int   results_seen;
   int   inside_seen;

   // Stimulus bookkeeping and flags read by the receiver process and by push_vertex.
   int   words_sent;
   int   polygons_sent;
   int   hold_requests;
   logic quiet_phase;
   logic steady_feed;

   // Receiver process state.
   int   holds_served;
   int   hold_left;
   int   rsp_idle_left;

   pip_req_if req_chan ();
   pip_rsp_if rsp_chan ();

   point_in_polygon_test_top u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   pip_crossing_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_chan),
      .rsp_mon      (rsp_chan),
      .run_done     (run_done),
      .fail_count   (fail_count),
      .results_seen (results_seen),
      .inside_seen  (inside_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop, far beyond the slowest correct run.
   initial begin
      #2000000;
      $display("Timed out with %0d of %0d results received.", results_seen, polygons_sent);
      $display("FAIL");
      $finish;
   end

   // Result side: random stall bursts, long holds on request, none at the end.
   initial begin
      holds_served  = 0;
      hold_left     = 0;
      rsp_idle_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            hold_left    = 300;
         end
         if (reset) begin
            rsp_chan.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (rsp_idle_left > 0) begin
            rsp_idle_left--;
            rsp_chan.ready <= 1'b0;
         end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
            rsp_idle_left = $urandom_range(1, 17) - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Offer one vertex word, maybe after an idle burst, and wait until it is taken.
   task automatic push_vertex(input vertex_type vx, input vertex_type vy,
                              input query_type qx, input query_type qy, input logic last);
      int gap;
      if (!quiet_phase && !steady_feed && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 17);
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.vertex_x    <= vx;
      req_chan.vertex_y    <= vy;
      req_chan.query_x     <= qx;
      req_chan.query_y     <= qy;
      req_chan.last_vertex <= last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      words_sent++;
      if (last) begin
         polygons_sent++;
      end
   endtask

   // Random polygon: local ones sit around the query point so edges really cross;
   // wide ones use the full field ranges.
   task automatic send_polygon(input int count, input logic wide);
      int         cx, cy;
      query_type  qx, qy;
      vertex_type vx, vy;
      if (wide) begin
         qx = query_type'($urandom);
         qy = query_type'($urandom);
         cx = 0;
         cy = 0;
      end else begin
         cx = int'($urandom_range(0, 400)) - 200;
         cy = int'($urandom_range(0, 400)) - 200;
         qx = query_type'(cx * FRAC_SCALE + int'($urandom_range(0, 1600)) - 800);
         qy = query_type'(cy * FRAC_SCALE + int'($urandom_range(0, 1600)) - 800);
      end
      for (int i = 0; i < count; i++) begin
         if (wide) begin
            vx = vertex_type'($urandom);
            vy = vertex_type'($urandom);
         end else begin
            vx = vertex_type'(cx + int'($urandom_range(0, 100)) - 50);
            vy = vertex_type'(cy + int'($urandom_range(0, 100)) - 50);
         end
         if (i == 0) begin
            push_vertex(vx, vy, qx, qy, count == 1);
         end else begin
            push_vertex(vx, vy, query_type'($urandom), query_type'($urandom), i == count - 1);
         end
      end
   endtask

   initial begin
      int n;
      words_sent    = 0;
      polygons_sent = 0;
      reset                <= 1'b1;
      run_done             <= 1'b0;
      hold_requests        <= 0;
      quiet_phase          <= 1'b0;
      steady_feed          <= 1'b0;
      req_chan.valid       <= 1'b0;
      req_chan.vertex_x    <= '0;
      req_chan.vertex_y    <= '0;
      req_chan.query_x     <= '0;
      req_chan.query_y     <= '0;
      req_chan.last_vertex <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Single-vertex polygon: the closing edge has zero length.
      push_vertex(5, 5, 0, 0, 1'b1);
      // Square around the query; the query fields on later words must be ignored.
      push_vertex(-10, -10, 24, 4, 1'b0);
      push_vertex(10, -10, -524288, 524287, 1'b0);
      push_vertex(10, 10, 524287, -524288, 1'b0);
      push_vertex(-10, 10, 0, 0, 1'b1);
      // Triangle well away from the query point.
      push_vertex(100, 200, -1600, -1600, 1'b0);
      push_vertex(300, 250, 0, 0, 1'b0);
      push_vertex(200, 400, 0, 0, 1'b1);
      // Query and vertex fields at their extremes.
      push_vertex(-32768, -32768, -524288, 524287, 1'b0);
      push_vertex(32767, 32767, 0, 0, 1'b0);
      push_vertex(32767, -32768, 0, 0, 1'b1);
      // A repeated vertex gives a zero-length edge.
      push_vertex(3, 3, 0, 0, 1'b0);
      push_vertex(3, 3, 0, 0, 1'b0);
      push_vertex(20, -5, 0, 0, 1'b0);
      push_vertex(-5, 20, 0, 0, 1'b1);
      // An edge lying on the test segment is parallel and does not count.
      push_vertex(-10, -10, 0, 0, 1'b0);
      push_vertex(10, 10, 0, 0, 1'b0);
      push_vertex(10, -20, 0, 0, 1'b1);
      // Two-vertex polygon across the far diagonal at the vertex extremes.
      push_vertex(-32768, 32767, 524287, -524288, 1'b0);
      push_vertex(32767, -32768, 0, 0, 1'b1);
      // Query exactly on an edge: the inclusive bound counts it.
      push_vertex(0, -10, 0, 0, 1'b0);
      push_vertex(0, 10, 0, 0, 1'b0);
      push_vertex(-10, 0, 0, 0, 1'b1);

      // Long result hold while short polygons keep coming, so the input stalls.
      steady_feed   <= 1'b1;
      hold_requests <= hold_requests + 1;
      for (int i = 0; i < 24; i++) begin
         send_polygon($urandom_range(1, 3), 1'b0);
      end
      steady_feed <= 1'b0;

      // Pause until every outstanding result has been taken.
      while (results_seen != polygons_sent) @(posedge clock);

      // Random polygons, with a second long hold midway and a quiet tail.
      while (words_sent < 580) begin
         if (words_sent >= 520) begin
            quiet_phase <= 1'b1;
         end
         if (words_sent >= 300 && hold_requests == 1) begin
            hold_requests <= 2;
         end
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
         send_polygon(n, $urandom_range(0, 4) == 0);
      end
      req_chan.valid <= 1'b0;

      // Drain the pipeline, then let the checker look for stragglers.
      while (results_seen < polygons_sent) @(posedge clock);
      repeat (8) @(posedge clock);
      run_done <= 1'b1;
      repeat (2) @(posedge clock);

      $display("Sent %0d vertex words in %0d polygons, including field extremes,",
               words_sent, polygons_sent);
      $display("degenerate and on-edge cases and stalled output; %0d of %0d results inside.",
               inside_seen, results_seen);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+design
design/pip_pkg.sv
design/pip_if.sv
design/pip_front.sv
design/pip_edge.sv
design/point_in_polygon_test_top.sv
tb/pip_crossing_checker.sv
tb/tb_point_in_polygon_test_top.sv
